### design/playfair_digraph_cipher_assert.svh
// Assertion macros used by the Playfair cipher top level.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH

// Same-cycle implication, checked on clk, off during rst.
`define PFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pfc_pkg.sv
// Types, constants and helper functions for the Playfair cipher.
package pfc_pkg;

  localparam int unsigned SqDim    = 5;
  localparam int unsigned MaxRes   = 4;
  localparam int unsigned NumCand  = 6;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] idx_t;                 // row or column, 0..4
  typedef letter_t [SqDim-1:0] row_t;        // column k at bits 5k
  typedef row_t [SqDim-1:0] square_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_ABSENT = 2'd1,
    ERR_ODD    = 2'd2
  } err_code_t;

  typedef enum logic [2:0] {
    REG_DECRYPT_MODE  = 3'd0,
    REG_FILLER_LETTER = 3'd1,
    REG_SQUARE_ROW0   = 3'd2,
    REG_SQUARE_ROW1   = 3'd3,
    REG_SQUARE_ROW2   = 3'd4,
    REG_SQUARE_ROW3   = 3'd5,
    REG_SQUARE_ROW4   = 3'd6
  } cfg_reg_t;

  localparam letter_t FILLER_RESET = 5'd23;
  localparam row_t ROW0_RESET = row_t'(25'd36043);
  localparam row_t ROW1_RESET = row_t'(25'd2235792);
  localparam row_t ROW2_RESET = row_t'(25'd5518900);
  localparam row_t ROW3_RESET = row_t'(25'd10963639);
  localparam row_t ROW4_RESET = row_t'(25'd16374553);

  typedef struct packed {
    letter_t letter_in;
    logic    end_of_message;
  } in_item_t;

  typedef struct packed {
    letter_t   letter_out;
    logic      has_letter;
    logic      run_last;
    logic      message_done;
    err_code_t error_code;
  } res_t;

  typedef struct packed {
    logic found;
    idx_t row;
    idx_t col;
  } loc_t;

  typedef struct packed {
    res_t item0;
    res_t item1;
    logic en0;
    logic en1;
  } pair_out_t;

  typedef struct packed {
    res_t [MaxRes-1:0] slots;
    logic [2:0]        count;
    logic              pend_valid_next;
    letter_t           pend_letter_next;
  } step_out_t;

  function automatic res_t make_res(letter_t l, logic has, err_code_t err);
    res_t r;
    r.letter_out   = has ? l : '0;
    r.has_letter   = has;
    r.run_last     = 1'b0;
    r.message_done = 1'b0;
    r.error_code   = err;
    return r;
  endfunction

  // +1 mod 5 when encrypting, -1 mod 5 when decrypting
  function automatic idx_t shift_idx(idx_t v, logic dec);
    idx_t r;
    if (dec) begin
      r = (v == 3'd0) ? 3'd4 : v - 3'd1;
    end else begin
      r = (v == 3'd4) ? 3'd0 : v + 3'd1;
    end
    return r;
  endfunction

endpackage

### design/playfair_digraph_cipher.sv
// Top level of the streaming Playfair digraph cipher.
//
// Channels: input beats (letter_in, end_of_message) on in_valid/in_stall,
// result beats on out_valid/out_stall; a beat moves when valid is high and
// stall is low. Config writes go on cfg_valid/cfg_ready (always ready), with
// cfg_index selecting decrypt_mode, filler_letter or square_row0..4.
// Config is to be written only while idle (unchecked); bad indexes ignored.
// Datapath: input register -> square lookups and digraph rules -> result
// buffer of up to four beats -> output register.
// Throughput: when out_stall is low, one result beat per cycle leaves the
// buffer; the next letter waits in the input register until the last beat
// of the one before leaves, so plain text runs near one letter per cycle.
// Stall: out_stall holds the output register, the buffer then fills and
// in_stall rises while a letter waits in the input register.
// Reset: key square, filler (x) and mode go to their defaults; the pending
// letter, buffer and both registers empty.
module playfair_digraph_cipher
  import pfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [24:0] cfg_data
);

  `include "playfair_digraph_cipher_assert.svh"

  // config registers
  logic    decrypt_mode;
  letter_t filler_letter;
  square_t square;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode  <= 1'b0;
      filler_letter <= FILLER_RESET;
      square        <= {ROW4_RESET, ROW3_RESET, ROW2_RESET, ROW1_RESET, ROW0_RESET};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DECRYPT_MODE:  decrypt_mode  <= cfg_data[0];
        REG_FILLER_LETTER: filler_letter <= cfg_data[4:0];
        REG_SQUARE_ROW0:   square[0]     <= cfg_data;
        REG_SQUARE_ROW1:   square[1]     <= cfg_data;
        REG_SQUARE_ROW2:   square[2]     <= cfg_data;
        REG_SQUARE_ROW3:   square[3]     <= cfg_data;
        REG_SQUARE_ROW4:   square[4]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic     in_q_valid;
  in_item_t in_q;

  // digraph state
  logic    pend_valid;
  letter_t pend_letter;

  // result buffer
  res_t [MaxRes-1:0] buf_res;
  logic [2:0]        buf_left;
  logic [1:0]        buf_rd;

  logic      buf_has, buf_free, out_ld, take, in_acc;
  step_out_t step;

  always_comb begin
    buf_has  = (buf_left != 3'd0);
    out_ld   = buf_has && (!out_valid || !out_stall);
    // buffer can take a new letter's results once its last beat leaves
    buf_free = !buf_has || ((buf_left == 3'd1) && out_ld);
    take     = in_q_valid && buf_free;
    in_stall = in_q_valid && !buf_free;
    in_acc   = in_valid && !in_stall;
  end

  pfc_step u_step (
    .letter     (in_q.letter_in),
    .eom        (in_q.end_of_message),
    .pend_valid (pend_valid),
    .pend_letter(pend_letter),
    .decrypt    (decrypt_mode),
    .filler     (filler_letter),
    .square     (square),
    .step       (step)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid  <= 1'b0;
      pend_valid  <= 1'b0;
      pend_letter <= '0;
      buf_left    <= '0;
      buf_rd      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (in_acc) begin
        in_q_valid <= 1'b1;
      end else if (take) begin
        in_q_valid <= 1'b0;
      end
      if (take) begin
        pend_valid  <= step.pend_valid_next;
        pend_letter <= step.pend_letter_next;
        buf_left    <= step.count;
        buf_rd      <= '0;
      end else if (out_ld) begin
        buf_left <= buf_left - 3'd1;
        buf_rd   <= buf_rd + 2'd1;
      end
      if (out_ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_q <= in_data;
    end
    if (take) begin
      buf_res <= step.slots;
    end
    if (out_ld) begin
      out_data <= buf_res[buf_rd];
    end
  end

  // buffer never holds more than four beats
  `PFC_ASSERT_NOW(a_buf_depth, 1'b1, buf_left <= 3'd4, "result buffer over depth")

  // input side only stalls on a held letter
  `PFC_ASSERT_NOW(a_stall_held, in_stall, in_q_valid, "stall without a held letter")

  // marker and error beats carry letter zero
  `PFC_ASSERT_NOW(a_marker_zero, out_valid && !out_data.has_letter,
                  out_data.letter_out == 5'd0, "letter set on a marker beat")

  // end of message always clears the pending letter
  `PFC_ASSERT_NEXT(a_eom_clear, take && in_q.end_of_message, !pend_valid,
                   "pending letter left after end of message")

endmodule

### design/pfc_locate.sv
// Finds the first row-major position of a letter in the key square.
module pfc_locate
  import pfc_pkg::*;
(
  input  letter_t letter,
  input  square_t square,
  output loc_t    loc
);

  always_comb begin
    loc = '0;
    // scan backwards so the earliest match wins
    for (int i = SqDim - 1; i >= 0; i--) begin
      for (int k = SqDim - 1; k >= 0; k--) begin
        if (square[i][k] == letter) begin
          loc.found = 1'b1;
          loc.row   = idx_t'(i);
          loc.col   = idx_t'(k);
        end
      end
    end
  end

endmodule

### design/pfc_pair.sv
// Digraph transform: row shift, column shift or rectangle swap.
module pfc_pair
  import pfc_pkg::*;
(
  input  loc_t      loc_a,
  input  loc_t      loc_b,
  input  square_t   square,
  input  logic      decrypt,
  input  letter_t   filler,
  output pair_out_t pair
);

  letter_t x, y;
  logic    absent;

  always_comb begin
    absent = !loc_a.found || !loc_b.found;
    if (loc_a.row == loc_b.row) begin
      x = square[loc_a.row][shift_idx(loc_a.col, decrypt)];
      y = square[loc_b.row][shift_idx(loc_b.col, decrypt)];
    end else if (loc_a.col == loc_b.col) begin
      x = square[shift_idx(loc_a.row, decrypt)][loc_a.col];
      y = square[shift_idx(loc_b.row, decrypt)][loc_b.col];
    end else begin
      x = square[loc_a.row][loc_b.col];
      y = square[loc_b.row][loc_a.col];
    end
  end

  always_comb begin
    pair.item0 = absent ? make_res('0, 1'b0, ERR_ABSENT) : make_res(x, 1'b1, ERR_NONE);
    pair.item1 = make_res(y, 1'b1, ERR_NONE);
    // decrypt drops filler letters
    pair.en0   = absent || !decrypt || (x != filler);
    pair.en1   = !absent && (!decrypt || (y != filler));
  end

endmodule

### design/pfc_step.sv
// Per-letter step: pairing decisions and the packed list of result beats.
module pfc_step
  import pfc_pkg::*;
(
  input  letter_t   letter,
  input  logic      eom,
  input  logic      pend_valid,
  input  letter_t   pend_letter,
  input  logic      decrypt,
  input  letter_t   filler,
  input  square_t   square,
  output step_out_t step
);

  loc_t      loc_l, loc_p, loc_f;
  loc_t      p1_b, p2_a;
  pair_out_t pair1, pair2;
  logic      absent, case_first, case_double, case_pair, pend_after, tail;

  pfc_locate u_loc_l (.letter(letter),      .square(square), .loc(loc_l));
  pfc_locate u_loc_p (.letter(pend_letter), .square(square), .loc(loc_p));
  pfc_locate u_loc_f (.letter(filler),      .square(square), .loc(loc_f));

  always_comb begin
    absent      = !loc_l.found;
    case_first  = !absent && !pend_valid;
    case_double = !absent && pend_valid && !decrypt && (pend_letter == letter);
    case_pair   = !absent && pend_valid && !case_double;
    pend_after  = absent ? pend_valid : !case_pair;
    tail        = eom && pend_after;
    p1_b        = case_double ? loc_f : loc_l;
    p2_a        = case_first ? loc_l : loc_p;
  end

  pfc_pair u_pair1 (
    .loc_a(loc_p), .loc_b(p1_b), .square(square),
    .decrypt(decrypt), .filler(filler), .pair(pair1)
  );

  pfc_pair u_pair2 (
    .loc_a(p2_a), .loc_b(loc_f), .square(square),
    .decrypt(decrypt), .filler(filler), .pair(pair2)
  );

  res_t [NumCand-1:0] cand;
  logic [NumCand-1:0] cand_en;
  logic [2:0]         n;

  always_comb begin
    cand[0]    = make_res('0, 1'b0, ERR_ABSENT);
    cand_en[0] = absent;
    cand[1]    = pair1.item0;
    cand_en[1] = (case_double || case_pair) && pair1.en0;
    cand[2]    = pair1.item1;
    cand_en[2] = (case_double || case_pair) && pair1.en1;
    cand[3]    = decrypt ? make_res('0, 1'b0, ERR_ODD) : pair2.item0;
    cand_en[3] = tail && (decrypt || pair2.en0);
    cand[4]    = pair2.item1;
    cand_en[4] = tail && !decrypt && pair2.en1;
    cand[5]    = make_res('0, 1'b0, ERR_NONE);           // end marker only
    cand_en[5] = eom && (cand_en[4:0] == '0);
  end

  // compact enabled candidates into slots, then tag the final one
  always_comb begin
    step.slots = '0;
    n          = '0;
    for (int i = 0; i < NumCand; i++) begin
      if (cand_en[i] && (n < 3'(MaxRes))) begin
        step.slots[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
    for (int i = 0; i < MaxRes; i++) begin
      if (3'(i) + 3'd1 == n) begin
        step.slots[i].run_last     = 1'b1;
        step.slots[i].message_done = eom;
      end
    end
    step.count = n;
    if (eom) begin
      step.pend_valid_next  = 1'b0;
      step.pend_letter_next = '0;
    end else if (case_first || case_double) begin
      step.pend_valid_next  = 1'b1;
      step.pend_letter_next = letter;
    end else begin
      step.pend_valid_next  = pend_after;
      step.pend_letter_next = pend_letter;
    end
  end

endmodule

### bench/playfair_digraph_cipher_tb.sv
// Self-checking testbench for the streaming Playfair digraph cipher.
module playfair_digraph_cipher_tb
  import pfc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 3000;  // cycles with no beat anywhere before giving up
  localparam int MaxReports = 10;
  localparam int HoldCycles = 60;    // long receiver hold-off, fills the result buffer
  localparam int SettleCycles = 8;   // a letter with no result can still be in flight

  // Tracks the cipher: its own copy of mode, filler, square and held letter, and
  // the queue of result beats that are due from the block.
  class cipher_tracker;
    logic    decrypt;
    letter_t filler;
    square_t sq;
    logic    held_valid;
    letter_t held_letter;
    res_t    due_beats[$];
    int      fail_count;

    function new();
      decrypt     = 1'b0;
      filler      = FILLER_RESET;
      sq[0]       = ROW0_RESET;
      sq[1]       = ROW1_RESET;
      sq[2]       = ROW2_RESET;
      sq[3]       = ROW3_RESET;
      sq[4]       = ROW4_RESET;
      held_valid  = 1'b0;
      held_letter = '0;
      fail_count  = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [24:0] val);
      case (idx)
        REG_DECRYPT_MODE: begin
          decrypt = val[0];
        end
        REG_FILLER_LETTER: begin
          filler = val[4:0];
        end
        default: begin
          sq[int'(idx) - int'(REG_SQUARE_ROW0)] = row_t'(val);
        end
      endcase
    endfunction

    // first hit in row-major order wins, so duplicate entries resolve early
    function bit locate(letter_t l, output idx_t r, output idx_t c);
      bit hit;
      hit = 1'b0;
      r   = '0;
      c   = '0;
      for (int i = 0; i < SqDim; i++) begin
        for (int k = 0; k < SqDim; k++) begin
          if (!hit && sq[i][k] == l) begin
            hit = 1'b1;
            r   = idx_t'(i);
            c   = idx_t'(k);
          end
        end
      end
      return hit;
    endfunction

    function void add_beat(letter_t l, logic has, err_code_t err);
      res_t b;
      b.letter_out   = has ? l : '0;
      b.has_letter   = has;
      b.run_last     = 1'b0;
      b.message_done = 1'b0;
      b.error_code   = err;
      due_beats.push_back(b);
    endfunction

    function void encode_pair(letter_t a, letter_t b);
      idx_t    ra, ca, rb, cb;
      int      d;
      letter_t x, y;
      bit      found_a, found_b;
      found_a = locate(a, ra, ca);
      found_b = locate(b, rb, cb);
      if (!found_a || !found_b) begin
        add_beat('0, 1'b0, ERR_ABSENT);
      end else begin
        d = decrypt ? 4 : 1;
        if (ra == rb) begin
          x = sq[ra][(int'(ca) + d) % SqDim];
          y = sq[rb][(int'(cb) + d) % SqDim];
        end else if (ca == cb) begin
          x = sq[(int'(ra) + d) % SqDim][ca];
          y = sq[(int'(rb) + d) % SqDim][cb];
        end else begin
          x = sq[ra][cb];
          y = sq[rb][ca];
        end
        // decrypting strips filler letters from the plaintext
        if (!decrypt || x != filler) add_beat(x, 1'b1, ERR_NONE);
        if (!decrypt || y != filler) add_beat(y, 1'b1, ERR_NONE);
      end
    endfunction

    // One accepted input beat: queue every result beat it causes.
    function void take_letter(in_item_t it);
      idx_t r, c;
      int   first;
      first = due_beats.size();
      if (!locate(it.letter_in, r, c)) begin
        add_beat('0, 1'b0, ERR_ABSENT);
      end else if (!held_valid) begin
        held_valid  = 1'b1;
        held_letter = it.letter_in;
      end else if (!decrypt && held_letter == it.letter_in) begin
        encode_pair(held_letter, filler);  // second copy stays held
      end else begin
        encode_pair(held_letter, it.letter_in);
        held_valid = 1'b0;
      end
      if (it.end_of_message) begin
        if (held_valid) begin
          if (decrypt) add_beat('0, 1'b0, ERR_ODD);
          else encode_pair(held_letter, filler);
        end
        held_valid  = 1'b0;
        held_letter = '0;
        if (due_beats.size() == first) add_beat('0, 1'b0, ERR_NONE);
        due_beats[due_beats.size() - 1].message_done = 1'b1;
      end
      if (due_beats.size() > first) due_beats[due_beats.size() - 1].run_last = 1'b1;
    endfunction

    function void match_beat(res_t got);
      res_t want;
      if (due_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("[%0t] extra beat: letter=%0d has=%0b last=%0b done=%0b err=%0d",
                   $realtime, got.letter_out, got.has_letter, got.run_last,
                   got.message_done, got.error_code);
      end else begin
        want = due_beats.pop_front();
        if (got.letter_out !== want.letter_out || got.has_letter !== want.has_letter ||
            got.run_last !== want.run_last || got.message_done !== want.message_done ||
            got.error_code !== want.error_code) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("[%0t] mismatch: want letter=%0d has=%0b last=%0b done=%0b err=%0d",
                     $realtime, want.letter_out, want.has_letter, want.run_last,
                     want.message_done, want.error_code);
            $display("    got letter=%0d has=%0b last=%0b done=%0b err=%0d",
                     got.letter_out, got.has_letter, got.run_last, got.message_done,
                     got.error_code);
          end
        end
      end
    endfunction
  endclass

  // Clock, reset, and every block input at a known value from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  res_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [24:0] cfg_data = '0;

  cipher_tracker sb = new();

  int tx_idle_pct = 0;    // chance per cycle that the sender holds back
  int rx_stall_pct = 0;   // chance per cycle that the receiver stalls
  bit hold_req = 1'b0;    // asks the receiver for one long hold-off
  int hold_left = 0;
  int quiet = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  playfair_digraph_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Receiver: check at the rising edge, choose next cycle's stall at the falling
  // edge. A requested hold-off is counted down here, independent of the sender.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.match_beat(out_data);
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d result beats still due",
               quiet, sb.due_beats.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Every driving task is entered and left at a falling edge.
  task automatic send_letter(letter_t l, logic eom);
    in_item_t it;
    it.letter_in      = l;
    it.end_of_message = eom;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.take_letter(it);
    @(negedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [24:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering letters and let the block empty out completely.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_beats.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both, lighter
  task automatic set_idling(int mode);
    tx_idle_pct  = (mode == 1) ? 71 : (mode == 3) ? 31 : 0;
    rx_stall_pct = (mode == 2) ? 71 : (mode == 3) ? 31 : 0;
  endtask

  function automatic square_t shuffled_square();
    letter_t pool[26];
    letter_t t;
    square_t s;
    int      i, j;
    for (i = 0; i < 26; i++) pool[i] = letter_t'(i);
    for (i = 25; i > 0; i--) begin
      j       = $urandom_range(i);
      t       = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    for (i = 0; i < 25; i++) s[i / SqDim][i % SqDim] = pool[i];
    return s;
  endfunction

  task automatic load_setup(int mode, logic dec, letter_t fil, square_t s);
    int r;
    drain();
    set_idling(mode);
    cfg_write(REG_DECRYPT_MODE, 25'(dec));
    cfg_write(REG_FILLER_LETTER, 25'(fil));
    for (r = 0; r < SqDim; r++) cfg_write(cfg_reg_t'(int'(REG_SQUARE_ROW0) + r), s[r]);
  endtask

  // Random messages: mostly letters of the current square with doubled letters
  // mixed in, some noise from the whole 5-bit code space, random lengths.
  task automatic run_messages(int count, bit with_hold, bit with_pause);
    int      sent, len, k, roll;
    letter_t l, prev;
    sent = 0;
    prev = '0;
    while (sent < count) begin
      len = $urandom_range(9, 1);
      for (k = 0; k < len && sent < count; k++) begin
        roll = $urandom_range(99);
        if (roll < 8) l = letter_t'($urandom_range(31));
        else if (roll < 22 && k > 0) l = prev;
        else l = sb.sq[$urandom_range(SqDim - 1)][$urandom_range(SqDim - 1)];
        if (with_hold && sent == count / 3) hold_req = 1'b1;
        if (with_pause && sent == count / 2) drain();
        send_letter(l, (k == len - 1) || (sent == count - 1));
        prev = l;
        sent++;
      end
    end
  endtask

  initial begin
    logic    dec;
    letter_t fil;
    square_t s;
    int      ph;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset square: l g d b a / q m h e c / u r n i f / x v s o k / z y w t p
    // Encrypt with filler x: same row, same column, rectangle, doubled letter.
    set_idling(0);
    send_letter(5'd0, 1'b0);
    send_letter(5'd1, 1'b0);
    send_letter(5'd11, 1'b0);
    send_letter(5'd16, 1'b0);
    send_letter(5'd6, 1'b0);
    send_letter(5'd14, 1'b0);
    send_letter(5'd4, 1'b0);
    send_letter(5'd4, 1'b0);    // doubled: e splits with filler, second e held
    send_letter(5'd19, 1'b0);
    send_letter(5'd9, 1'b0);    // j is not in the square
    send_letter(5'd31, 1'b0);   // code past z
    send_letter(5'd25, 1'b1);   // odd end: padded with filler
    send_letter(5'd23, 1'b0);
    send_letter(5'd23, 1'b1);   // filler twice, then padded: four beats

    // Decrypt: v v decodes to two fillers, both dropped, so only a marker beat.
    drain();
    cfg_write(REG_DECRYPT_MODE, 25'd1);
    send_letter(5'd21, 1'b0);
    send_letter(5'd21, 1'b1);
    send_letter(5'd10, 1'b0);
    send_letter(5'd22, 1'b0);
    send_letter(5'd2, 1'b1);    // odd length while decrypting
    send_letter(5'd26, 1'b1);   // absent letter closing an empty message

    // Filler outside the square, then a held letter that a new square loses.
    drain();
    set_idling(1);
    cfg_write(REG_DECRYPT_MODE, 25'd0);
    cfg_write(REG_FILLER_LETTER, 25'd9);
    send_letter(5'd0, 1'b0);
    send_letter(5'd0, 1'b0);    // doubled pair needs the absent filler
    send_letter(5'd1, 1'b0);
    send_letter(5'd6, 1'b0);    // g held across the square change
    drain();
    cfg_write(REG_SQUARE_ROW0, 25'd0);   // row of five a, g and b gone
    send_letter(5'd7, 1'b1);
    send_letter(5'd0, 1'b0);    // duplicate a: first match is column zero
    send_letter(5'd16, 1'b1);

    // Random phases over the idling modes; the first three hit the extremes.
    for (ph = 0; ph < 8; ph++) begin
      dec = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(1));
      fil = (ph == 0) ? 5'd0 : (ph == 1) ? 5'd25 : letter_t'($urandom_range(25));
      s   = shuffled_square();
      if (ph == 2) begin
        s[0] = '0;
        s[4] = '1;
      end
      load_setup(ph % 4, dec, fil, s);
      run_messages(19, ph == 4, ph == 5);
    end

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (sb.due_beats.size() != 0) begin
      sb.fail_count++;
      $display("%0d result beats never arrived", sb.due_beats.size());
    end
    if (sb.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
